// ===== hdl/mcbd_pkg.sv =====
`timescale 1ns / 1ps
package mcbd_pkg;

	// field widths
	localparam int CH_W    = 8;
	localparam int DIM_W   = 13;
	localparam int CRD_W   = 12;
	localparam int LVL_W   = 4;
	localparam int IDX_W   = 15;
	localparam int SUM_W   = 10;
	localparam int CFG_W   = 13;
	localparam int CFG_A_W = 3;
	localparam int MAX_HEIGHT = 4096;

	// register indexes
	localparam logic [CFG_A_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_A_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_A_W-1:0] REG_LEVELS = 3'd2;
	localparam logic [CFG_A_W-1:0] REG_FOUR   = 3'd3;
	localparam logic [CFG_A_W-1:0] REG_ALPHA  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic read;
		logic eval;
		logic emit;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic cont;
	} status_t;

endpackage

// ===== hdl/mipmap_chain_box_downsampler.sv =====
`timescale 1ns / 1ps
// Mip chain builder with a 2x2 box filter.
// Base pixels enter on the s_ side in raster order, one transaction per pixel.
// Each pixel leaves on the m_ side as its level-0 result, followed by every
// coarser-level pixel it completes; tlast marks the final result of the pixel.
// Width, height, level count and channel format are set through the cfg port;
// the user writes them only while the block is idle, and the block itself
// has no check for this. Any register write restarts the frame at 0,0. Each
// result of a pixel, from level 0 upward, takes a store read, an evaluate
// step and an output load in turn, through the single-port pair-sum memory,
// and the output load waits while the receiver stalls.
// A stalled receiver holds the output register; the block waits in its emit
// step and takes no new pixel until the pending results drain, but accepts
// the next pixel while the last result still sits in the output register.
// Reset clears the frame position, held pixels and registers to their
// defaults (1x1, one level, RGBA, source alpha valid). The pair-sum memory
// is not cleared; a frame writes each slot before reading it.
module mipmap_chain_box_downsampler #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_LEVELS = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,   // red_in, green_in, blue_in, alpha_in
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [63:0]                  m_tdata,   // level, column, row, red_out,
	                                                // green_out, blue_out, alpha_out, pad
	output logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [mcbd_pkg::CFG_A_W-1:0] cfg_index,
	input  logic [mcbd_pkg::CFG_W-1:0]   cfg_data
);

	mcbd_pkg::cmd_t    cmd;
	mcbd_pkg::status_t sts;

	mcbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcbd_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tlast   (m_tlast),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== hdl/mcbd_ctrl.sv =====
`timescale 1ns / 1ps
module mcbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  mcbd_pkg::status_t sts,
	output mcbd_pkg::cmd_t    cmd
);

	mcbd_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mcbd_pkg::ST_IDLE: begin
				if (s_tvalid) state_nx = mcbd_pkg::ST_READ;
			end
			mcbd_pkg::ST_READ: state_nx = mcbd_pkg::ST_EVAL;
			mcbd_pkg::ST_EVAL: state_nx = mcbd_pkg::ST_EMIT;
			mcbd_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					state_nx = sts.cont ? mcbd_pkg::ST_READ : mcbd_pkg::ST_IDLE;
				end
			end
			default: state_nx = mcbd_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			mcbd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			mcbd_pkg::ST_READ: cmd.read = 1'b1;
			mcbd_pkg::ST_EVAL: cmd.eval = 1'b1;
			mcbd_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
				cmd.step = sts.out_free & sts.cont;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/mcbd_dp.sv =====
`timescale 1ns / 1ps
module mcbd_dp #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_LEVELS = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [31:0]                  s_tdata,
	output logic [63:0]                  m_tdata,
	output logic                         m_tvalid,
	output logic                         m_tlast,
	input  logic                         m_tready,
	input  logic                         cfg_we,
	input  logic [mcbd_pkg::CFG_A_W-1:0] cfg_index,
	input  logic [mcbd_pkg::CFG_W-1:0]   cfg_data,
	input  mcbd_pkg::cmd_t               cmd,
	output mcbd_pkg::status_t            sts
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int DW = mcbd_pkg::DIM_W;
	localparam int SW = mcbd_pkg::SUM_W;

	// configuration
	logic [DW-1:0] cfg_w_q, cfg_h_q;
	logic [3:0]    cfg_lv_q;
	logic          four_q, has_alpha_q;
	logic [DW-1:0] wc, hc;
	logic [4:0]    lc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q     <= DW'(1);
			cfg_h_q     <= DW'(1);
			cfg_lv_q    <= 4'd1;
			four_q      <= 1'b1;
			has_alpha_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				mcbd_pkg::REG_WIDTH:  cfg_w_q     <= cfg_data;
				mcbd_pkg::REG_HEIGHT: cfg_h_q     <= cfg_data;
				mcbd_pkg::REG_LEVELS: cfg_lv_q    <= cfg_data[3:0];
				mcbd_pkg::REG_FOUR:   four_q      <= cfg_data[0];
				mcbd_pkg::REG_ALPHA:  has_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic cfg_hit;
	assign cfg_hit = cfg_we && (cfg_index == mcbd_pkg::REG_WIDTH ||
		cfg_index == mcbd_pkg::REG_HEIGHT || cfg_index == mcbd_pkg::REG_LEVELS ||
		cfg_index == mcbd_pkg::REG_FOUR || cfg_index == mcbd_pkg::REG_ALPHA);

	// clamped geometry of the base level
	always_comb begin
		wc = cfg_w_q;
		if (cfg_w_q == '0) wc = DW'(1);
		else if (32'(cfg_w_q) > MAX_WIDTH) wc = DW'(MAX_WIDTH);
		hc = cfg_h_q;
		if (cfg_h_q == '0) hc = DW'(1);
		else if (32'(cfg_h_q) > mcbd_pkg::MAX_HEIGHT) hc = DW'(mcbd_pkg::MAX_HEIGHT);
		lc = {1'b0, cfg_lv_q};
		if (cfg_lv_q == '0) lc = 5'd1;
		else if (32'(cfg_lv_q) > MAX_LEVELS) lc = 5'(MAX_LEVELS);
	end

	// base-level position
	logic [DW-1:0] x0_q, y0_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q <= '0;
			y0_q <= '0;
		end else if (cfg_hit) begin
			x0_q <= '0;
			y0_q <= '0;
		end else if (cmd.load) begin
			if (x0_q + DW'(1) >= wc) begin
				x0_q <= '0;
				y0_q <= (y0_q + DW'(1) >= hc) ? '0 : y0_q + DW'(1);
			end else begin
				x0_q <= x0_q + DW'(1);
			end
		end
	end

	// working pixel of the current level
	logic [mcbd_pkg::LVL_W-1:0] lvl_q;
	logic [DW-1:0]              x_q, y_q, w_q, h_q;
	logic [mcbd_pkg::IDX_W-1:0] base_q;
	logic [31:0]                p_q, q_q;
	logic                       cont_q;

	logic          hf2, vf2, en, in_rng, idx_ok;
	logic [DW-1:0] w1, h1, nx, ny;
	logic [mcbd_pkg::IDX_W-1:0] idx;

	assign hf2    = w_q > DW'(1);
	assign vf2    = h_q > DW'(1);
	assign w1     = hf2 ? (w_q >> 1) : DW'(1);
	assign h1     = vf2 ? (h_q >> 1) : DW'(1);
	assign nx     = hf2 ? (x_q >> 1) : x_q;
	assign ny     = vf2 ? (y_q >> 1) : y_q;
	assign idx    = base_q + mcbd_pkg::IDX_W'(nx);
	assign idx_ok = 32'(idx) < MAX_WIDTH;
	assign en     = ({1'b0, lvl_q} + 5'd1) < lc;
	assign in_rng = (nx < w1) && (ny < h1);

	// pair-sum store, undefined until written
	logic [4*SW-1:0] store_mem [MAX_WIDTH];
	logic [4*SW-1:0] rd_s1;
	logic [31:0]     held_q [MAX_LEVELS];

	// column pair sum of the current pixel and the held left pixel
	logic [SW-1:0]   pair [4];
	logic [SW:0]     tot;
	logic [31:0]     q_nx;
	logic            pair_go, store_go, out_go;

	always_comb begin
		pair_go  = en && in_rng && !(hf2 && !x_q[0]);
		store_go = pair_go && vf2 && !y_q[0];
		out_go   = pair_go && !store_go;
		q_nx     = '0;
		for (int c = 0; c < 4; c++) begin
			pair[c] = SW'(p_q[8*c +: 8]) +
				(hf2 ? SW'(held_q[lvl_q[LW-1:0]][8*c +: 8]) : SW'(0));
			tot = {1'b0, pair[c]} + ((vf2 && idx_ok) ? {1'b0, rd_s1[SW*c +: SW]} : '0);
			tot = tot >> ({1'b0, hf2} + {1'b0, vf2});
			q_nx[8*c +: 8] = tot[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) rd_s1 <= store_mem[idx[AW-1:0]];
		if (cmd.eval && store_go && idx_ok) begin
			store_mem[idx[AW-1:0]] <= {pair[3], pair[2], pair[1], pair[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) held_q[i] <= '0;
		end else if (cmd.eval && en && in_rng && hf2 && !x_q[0]) begin
			held_q[lvl_q[LW-1:0]] <= p_q;
		end
	end

	// level sequencing
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lvl_q  <= '0;
			x_q    <= x0_q;
			y_q    <= y0_q;
			w_q    <= wc;
			h_q    <= hc;
			base_q <= '0;
			p_q    <= {has_alpha_q ? s_tdata[31:24] : 8'hFF, s_tdata[23:0]};
		end else if (cmd.step) begin
			lvl_q  <= lvl_q + mcbd_pkg::LVL_W'(1);
			x_q    <= nx;
			y_q    <= ny;
			w_q    <= w1;
			h_q    <= h1;
			base_q <= base_q + mcbd_pkg::IDX_W'(w1);
			p_q    <= q_q;
		end
		if (cmd.eval) begin
			q_q    <= q_nx;
			cont_q <= out_go;
		end
	end

	// output register
	logic out_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= {4'd0, four_q ? p_q[31:24] : 8'd0, p_q[23:0],
				y_q[mcbd_pkg::CRD_W-1:0], x_q[mcbd_pkg::CRD_W-1:0], lvl_q};
			m_tlast <= !cont_q;
		end
	end

	assign m_tvalid     = out_v_q;
	assign sts.out_free = !out_v_q || m_tready;
	assign sts.cont     = cont_q;

endmodule

// ===== hdl/mcbd_checker.sv =====
`timescale 1ns / 1ps
module mcbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast
);

	// one pixel at a time: an accepted pixel blocks the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted pixel");

	// results still owed for this pixel keep the input closed
	a_pending_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready with results of the pixel pending");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind mipmap_chain_box_downsampler mcbd_checker u_mcbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
